/* hdl/slt_pkg.sv */
// Shared types, token codes and keyword table for the script lexer.
// No dependencies; imported by every module of the block.
package slt_pkg;

    // Counter and field widths
    localparam int POS_BITS   = 24;
    localparam int KW_MAX_LEN = 6;
    localparam int KW_COUNT   = 16;
    localparam int WORD_BITS  = 8 * KW_MAX_LEN;

    typedef logic [POS_BITS-1:0]  pos_t;
    typedef logic [5:0]           ttype_t;
    typedef logic [WORD_BITS-1:0] word_t;

    localparam pos_t POS_MAX = {POS_BITS{1'b1}};
    localparam pos_t POS_ONE = pos_t'(1);

    // One token as it leaves the block
    typedef struct packed {
        ttype_t ttype;
        pos_t   start;
        pos_t   len;
        pos_t   line;
    } tok_t;

    // Tokens produced by one source byte (one to three)
    typedef struct packed {
        tok_t [2:0]  tok;
        logic [1:0]  cnt;
        logic        last;
    } bundle_t;

    // Token type codes
    localparam ttype_t TK_LPAREN      = 6'd0;
    localparam ttype_t TK_RPAREN      = 6'd1;
    localparam ttype_t TK_LBRACE      = 6'd2;
    localparam ttype_t TK_RBRACE      = 6'd3;
    localparam ttype_t TK_COMMA       = 6'd4;
    localparam ttype_t TK_DOT         = 6'd5;
    localparam ttype_t TK_MINUS       = 6'd6;
    localparam ttype_t TK_PLUS        = 6'd7;
    localparam ttype_t TK_SEMI        = 6'd8;
    localparam ttype_t TK_SLASH       = 6'd9;
    localparam ttype_t TK_STAR        = 6'd10;
    localparam ttype_t TK_BANG        = 6'd11;
    localparam ttype_t TK_BANG_EQ     = 6'd12;
    localparam ttype_t TK_EQ          = 6'd13;
    localparam ttype_t TK_EQ_EQ       = 6'd14;
    localparam ttype_t TK_GT          = 6'd15;
    localparam ttype_t TK_GT_EQ       = 6'd16;
    localparam ttype_t TK_LT          = 6'd17;
    localparam ttype_t TK_LT_EQ       = 6'd18;
    localparam ttype_t TK_IDENT       = 6'd19;
    localparam ttype_t TK_STRING      = 6'd20;
    localparam ttype_t TK_NUMBER      = 6'd21;
    localparam ttype_t TK_KW_FIRST    = 6'd22;
    localparam ttype_t TK_END         = 6'd38;
    localparam ttype_t TK_ERR_CHAR    = 6'd39;
    localparam ttype_t TK_ERR_STR     = 6'd40;
    localparam ttype_t TK_ERR_COMMENT = 6'd41;

    // Keywords, first character in the lowest byte, zero padded.
    // Order: and class else false fun for if nil or print return super
    // this true var while
    localparam word_t KW_TEXT [KW_COUNT] = '{
        48'h000000646E61, 48'h007373616C63, 48'h000065736C65, 48'h0065736C6166,
        48'h0000006E7566, 48'h000000726F66, 48'h000000006669, 48'h0000006C696E,
        48'h00000000726F, 48'h00746E697270, 48'h6E7275746572, 48'h007265707573,
        48'h000073696874, 48'h000065757274, 48'h000000726176, 48'h00656C696877
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd3,
        3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
    };

    // Saturating counter helpers
    function automatic pos_t sat_inc(input pos_t v);
        return (v == POS_MAX) ? POS_MAX : v + POS_ONE;
    endfunction

    function automatic pos_t sat_add(input pos_t a, input pos_t b);
        logic [POS_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, POS_MAX}) ? POS_MAX : s[POS_BITS-1:0];
    endfunction

endpackage

/* hdl/script_lexer_tokenizer_unit.sv */
// Top level of the script lexer: scanner front end, bundle queue and token
// output stage. Depends on slt_pkg, slt_front, slt_queue, slt_back.
//
// Usage:
//   Source bytes enter on the s_ channel (s_ch, s_final_byte), one beat per
//   byte; s_final_byte marks the last byte of a source text. Tokens leave on
//   the m_ channel, one beat per token: type, start offset, length, line and
//   is_last, which is set on the end token that closes each source text.
//   A byte yields zero to three tokens; they are grouped per byte in a queue
//   of QUEUE_DEPTH bundles.
//   Throughput: one byte per cycle on the input while the queue has room;
//   one token per cycle on the output while m_ready is high and tokens wait.
//   The tokens of an accepted byte are registered into the queue and from
//   there into the output stage, which presents the first of them once it
//   is free.
//   Receiver stall: tokens wait in the output stage and the queue; s_ready
//   drops only when the queue is full.
//   Reset: scanner state returns to idle with offset 0 and line 1, the queue
//   empties and m_valid drops. The same scanner state is restored after every
//   final byte, so the next source text starts fresh.
module script_lexer_tokenizer_unit
    import slt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_ch,
    input  logic                s_final_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [5:0]          m_token_type,
    output logic [POS_BITS-1:0] m_start_pos,
    output logic [POS_BITS-1:0] m_length,
    output logic [POS_BITS-1:0] m_line_no,
    output logic                m_is_last
);

    logic    q_push;
    bundle_t q_push_data;
    logic    q_full;
    logic    q_pop;
    logic    q_empty;
    bundle_t q_head;

    slt_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_ch         (s_ch),
        .s_final_byte (s_final_byte),
        .q_full       (q_full),
        .push         (q_push),
        .push_data    (q_push_data)
    );

    slt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    slt_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .pop          (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_token_type (m_token_type),
        .m_start_pos  (m_start_pos),
        .m_length     (m_length),
        .m_line_no    (m_line_no),
        .m_is_last    (m_is_last)
    );

endmodule

/* hdl/slt_front.sv */
// Scanner front end: accepts source bytes, runs the scan state machine and
// emits the tokens of each byte as one bundle. Depends on slt_pkg.
module slt_front
    import slt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  logic [7:0] s_ch,
    input  logic    s_final_byte,
    input  logic    q_full,
    output logic    push,
    output bundle_t push_data
);

    // Scan modes
    localparam logic [3:0] M_IDLE  = 4'd0;
    localparam logic [3:0] M_OP    = 4'd1;
    localparam logic [3:0] M_SLASH = 4'd2;
    localparam logic [3:0] M_LCOMM = 4'd3;
    localparam logic [3:0] M_BCOMM = 4'd4;
    localparam logic [3:0] M_BSTAR = 4'd5;
    localparam logic [3:0] M_STR   = 4'd6;
    localparam logic [3:0] M_INT   = 4'd7;
    localparam logic [3:0] M_DOT   = 4'd8;
    localparam logic [3:0] M_FRAC  = 4'd9;
    localparam logic [3:0] M_WORD  = 4'd10;

    // Pending operator codes
    localparam logic [1:0] OP_EQ   = 2'd0;
    localparam logic [1:0] OP_LT   = 2'd1;
    localparam logic [1:0] OP_GT   = 2'd2;
    localparam logic [1:0] OP_BANG = 2'd3;

    // Characters
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_EQUAL  = "=";
    localparam logic [7:0] CH_LESS   = "<";
    localparam logic [7:0] CH_GREATER = ">";
    localparam logic [7:0] CH_BANG   = "!";
    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_CR     = "\r";
    localparam logic [7:0] CH_TAB    = "\t";
    localparam logic [7:0] CH_NL     = "\n";
    localparam logic [7:0] CH_QUOTE  = "\"";
    localparam logic [7:0] CH_UNDER  = "_";
    localparam logic [7:0] CH_DIG0   = "0";
    localparam logic [7:0] CH_DIG9   = "9";
    localparam logic [7:0] CH_LOW_A  = "a";
    localparam logic [7:0] CH_LOW_Z  = "z";
    localparam logic [7:0] CH_UP_A   = "A";
    localparam logic [7:0] CH_UP_Z   = "Z";

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_DIG0) && (c <= CH_DIG9);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) ||
               ((c >= CH_UP_A) && (c <= CH_UP_Z)) || (c == CH_UNDER);
    endfunction

    function automatic ttype_t op_one(input logic [1:0] op);
        ttype_t t;
        unique case (op)
            OP_EQ:   t = TK_EQ;
            OP_LT:   t = TK_LT;
            OP_GT:   t = TK_GT;
            default: t = TK_BANG;
        endcase
        return t;
    endfunction

    function automatic ttype_t op_two(input logic [1:0] op);
        ttype_t t;
        unique case (op)
            OP_EQ:   t = TK_EQ_EQ;
            OP_LT:   t = TK_LT_EQ;
            OP_GT:   t = TK_GT_EQ;
            default: t = TK_BANG_EQ;
        endcase
        return t;
    endfunction

    // Keyword match on the buffered prefix; bytes above the length are zero
    function automatic ttype_t word_type(input word_t wb, input pos_t tl);
        ttype_t t;
        t = TK_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (tl == pos_t'(KW_LEN[k]) && wb == KW_TEXT[k]) begin
                t = TK_KW_FIRST + ttype_t'(k);
            end
        end
        return t;
    endfunction

    function automatic tok_t make_tok(input ttype_t t, input pos_t st, input pos_t ln,
                                      input pos_t li);
        tok_t r;
        r.ttype = t;
        r.start = st;
        r.len   = ln;
        r.line  = li;
        return r;
    endfunction

    logic [3:0] mode_reg, mode_next;
    logic [1:0] pend_reg, pend_next;
    word_t      word_reg, word_next;
    pos_t       tstart_reg, tstart_next;
    pos_t       tlen_reg, tlen_next;
    pos_t       pos_reg, pos_next;
    pos_t       line_reg, line_next;

    logic       accept;
    logic       line_up;
    logic       redo;
    logic       single_hit;
    ttype_t     single_type;
    logic [1:0] n;
    tok_t [3:0] slot;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign pos_next = sat_inc(pos_reg);

    // Scan step for one byte: mode transition, then restart, then end flush
    always_comb begin
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        word_next   = word_reg;
        tstart_next = tstart_reg;
        tlen_next   = tlen_reg;
        line_up     = 1'b0;
        redo        = 1'b0;
        single_hit  = 1'b0;
        single_type = TK_ERR_CHAR;
        n           = '0;
        slot        = '0;

        unique case (mode_reg) inside
            M_OP: begin
                if (s_ch == CH_EQUAL) begin
                    slot[n] = make_tok(op_two(pend_reg), tstart_reg, sat_inc(tlen_reg),
                                       line_reg);
                    n = n + 2'd1;
                    mode_next = M_IDLE;
                end else begin
                    slot[n] = make_tok(op_one(pend_reg), tstart_reg, tlen_reg, line_reg);
                    n = n + 2'd1;
                    redo = 1'b1;
                end
            end
            M_SLASH: begin
                tlen_next = sat_inc(tlen_reg);
                if (s_ch == CH_SLASH) begin
                    mode_next = M_LCOMM;
                end else if (s_ch == CH_STAR) begin
                    mode_next = M_BCOMM;
                end else begin
                    slot[n] = make_tok(TK_SLASH, tstart_reg, POS_ONE, line_reg);
                    n = n + 2'd1;
                    redo = 1'b1;
                end
            end
            M_LCOMM: begin
                if (s_ch == CH_NL) begin
                    line_up   = 1'b1;
                    mode_next = M_IDLE;
                end
            end
            M_BCOMM, M_BSTAR: begin
                tlen_next = sat_inc(tlen_reg);
                if (mode_reg == M_BSTAR && s_ch == CH_SLASH) begin
                    mode_next = M_IDLE;
                end else if (s_ch == CH_STAR) begin
                    mode_next = M_BSTAR;
                end else begin
                    line_up   = (s_ch == CH_NL);
                    mode_next = M_BCOMM;
                end
            end
            M_STR: begin
                tlen_next = sat_inc(tlen_reg);
                if (s_ch == CH_NL) begin
                    line_up = 1'b1;
                end else if (s_ch == CH_QUOTE) begin
                    slot[n] = make_tok(TK_STRING, tstart_reg, tlen_next, line_reg);
                    n = n + 2'd1;
                    mode_next = M_IDLE;
                end
            end
            M_INT: begin
                if (is_digit(s_ch)) begin
                    tlen_next = sat_inc(tlen_reg);
                end else if (s_ch == CH_DOT) begin
                    mode_next = M_DOT;
                end else begin
                    slot[n] = make_tok(TK_NUMBER, tstart_reg, tlen_reg, line_reg);
                    n = n + 2'd1;
                    redo = 1'b1;
                end
            end
            M_DOT: begin
                if (is_digit(s_ch)) begin
                    tlen_next = sat_add(tlen_reg, pos_t'(2));
                    mode_next = M_FRAC;
                end else begin
                    // held-back dot becomes its own token
                    slot[n] = make_tok(TK_NUMBER, tstart_reg, tlen_reg, line_reg);
                    n = n + 2'd1;
                    slot[n] = make_tok(TK_DOT, sat_add(tstart_reg, tlen_reg), POS_ONE,
                                       line_reg);
                    n = n + 2'd1;
                    redo = 1'b1;
                end
            end
            M_FRAC: begin
                if (is_digit(s_ch)) begin
                    tlen_next = sat_inc(tlen_reg);
                end else begin
                    slot[n] = make_tok(TK_NUMBER, tstart_reg, tlen_reg, line_reg);
                    n = n + 2'd1;
                    redo = 1'b1;
                end
            end
            M_WORD: begin
                if (is_alpha(s_ch) || is_digit(s_ch)) begin
                    for (int i = 0; i < KW_MAX_LEN; i++) begin
                        if (tlen_reg == pos_t'(i)) begin
                            word_next[8*i +: 8] = word_reg[8*i +: 8] | s_ch;
                        end
                    end
                    tlen_next = sat_inc(tlen_reg);
                end else begin
                    slot[n] = make_tok(word_type(word_reg, tlen_reg), tstart_reg, tlen_reg,
                                       line_reg);
                    n = n + 2'd1;
                    redo = 1'b1;
                end
            end
            default: redo = 1'b1;
        endcase

        // Start a new token at this byte
        if (redo) begin
            mode_next   = M_IDLE;
            tstart_next = pos_reg;
            tlen_next   = POS_ONE;
            unique case (s_ch) inside
                CH_LPAREN: begin single_hit = 1'b1; single_type = TK_LPAREN; end
                CH_RPAREN: begin single_hit = 1'b1; single_type = TK_RPAREN; end
                CH_LBRACE: begin single_hit = 1'b1; single_type = TK_LBRACE; end
                CH_RBRACE: begin single_hit = 1'b1; single_type = TK_RBRACE; end
                CH_COMMA:  begin single_hit = 1'b1; single_type = TK_COMMA; end
                CH_DOT:    begin single_hit = 1'b1; single_type = TK_DOT; end
                CH_MINUS:  begin single_hit = 1'b1; single_type = TK_MINUS; end
                CH_PLUS:   begin single_hit = 1'b1; single_type = TK_PLUS; end
                CH_SEMI:   begin single_hit = 1'b1; single_type = TK_SEMI; end
                CH_STAR:   begin single_hit = 1'b1; single_type = TK_STAR; end
                CH_SLASH:  mode_next = M_SLASH;
                CH_EQUAL:  begin mode_next = M_OP; pend_next = OP_EQ; end
                CH_LESS:   begin mode_next = M_OP; pend_next = OP_LT; end
                CH_GREATER: begin mode_next = M_OP; pend_next = OP_GT; end
                CH_BANG:   begin mode_next = M_OP; pend_next = OP_BANG; end
                CH_SPACE, CH_CR, CH_TAB: begin
                end
                CH_NL:     line_up = 1'b1;
                CH_QUOTE:  mode_next = M_STR;
                [CH_DIG0:CH_DIG9]: mode_next = M_INT;
                [CH_LOW_A:CH_LOW_Z], [CH_UP_A:CH_UP_Z], CH_UNDER: begin
                    mode_next = M_WORD;
                    word_next = word_t'(s_ch);
                end
                default: single_hit = 1'b1;
            endcase
            if (single_hit) begin
                slot[n] = make_tok(single_type, pos_reg, POS_ONE, line_reg);
                n = n + 2'd1;
            end
        end

        line_next = line_up ? sat_inc(line_reg) : line_reg;

        // Last byte: flush the open token, keep first and last, then the end token
        if (s_final_byte) begin
            unique case (mode_next) inside
                M_OP: begin
                    slot[n] = make_tok(op_one(pend_next), tstart_next, tlen_next, line_next);
                    n = n + 2'd1;
                end
                M_SLASH: begin
                    slot[n] = make_tok(TK_SLASH, tstart_next, POS_ONE, line_next);
                    n = n + 2'd1;
                end
                M_BCOMM, M_BSTAR: begin
                    slot[n] = make_tok(TK_ERR_COMMENT, tstart_next, tlen_next, line_next);
                    n = n + 2'd1;
                end
                M_STR: begin
                    slot[n] = make_tok(TK_ERR_STR, tstart_next, tlen_next, line_next);
                    n = n + 2'd1;
                end
                M_INT, M_FRAC: begin
                    slot[n] = make_tok(TK_NUMBER, tstart_next, tlen_next, line_next);
                    n = n + 2'd1;
                end
                M_DOT: begin
                    slot[n] = make_tok(TK_NUMBER, tstart_next, tlen_next, line_next);
                    n = n + 2'd1;
                    slot[n] = make_tok(TK_DOT, sat_add(tstart_next, tlen_next), POS_ONE,
                                       line_next);
                    n = n + 2'd1;
                end
                M_WORD: begin
                    slot[n] = make_tok(word_type(word_next, tlen_next), tstart_next,
                                       tlen_next, line_next);
                    n = n + 2'd1;
                end
                default: begin
                end
            endcase
            if (n == 2'd3) begin
                slot[1] = slot[2];
                n = 2'd2;
            end
            slot[n] = make_tok(TK_END, pos_next, '0, line_next);
            n = n + 2'd1;
        end
    end

    assign push           = accept && (n != 2'd0);
    assign push_data.tok  = slot[2:0];
    assign push_data.cnt  = n;
    assign push_data.last = s_final_byte;

    // Scanner state; the final byte returns everything to reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            pend_reg   <= OP_EQ;
            word_reg   <= '0;
            tstart_reg <= '0;
            tlen_reg   <= '0;
            pos_reg    <= '0;
            line_reg   <= POS_ONE;
        end else if (accept) begin
            if (s_final_byte) begin
                mode_reg   <= M_IDLE;
                pend_reg   <= OP_EQ;
                word_reg   <= '0;
                tstart_reg <= '0;
                tlen_reg   <= '0;
                pos_reg    <= '0;
                line_reg   <= POS_ONE;
            end else begin
                mode_reg   <= mode_next;
                pend_reg   <= pend_next;
                word_reg   <= word_next;
                tstart_reg <= tstart_next;
                tlen_reg   <= tlen_next;
                pos_reg    <= pos_next;
                line_reg   <= line_next;
            end
        end
    end

    // Checks
    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_final_byte |=> mode_reg == M_IDLE && pos_reg == '0 &&
                                   line_reg == POS_ONE)
        else $error("scanner state not cleared after final byte");

    a_line_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_final_byte |=> line_reg >= $past(line_reg))
        else $error("line counter went backwards within a source");

    a_final_has_end: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_final_byte |-> push && push_data.tok[n - 2'd1].ttype == TK_END)
        else $error("final byte bundle lacks end token");

endmodule

/* hdl/slt_queue.sv */
// Bundle queue between scanner front end and token output stage.
// Small register file with push/pop pointers. Depends on slt_pkg.
module slt_queue
    import slt_pkg::*;
#(
    parameter int DEPTH = 4
)(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  bundle_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    empty,
    output bundle_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!push && pop) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Checks
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full || pop)
        else $error("bundle queue written while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("bundle queue read while empty");

endmodule

/* hdl/slt_back.sv */
// Token output stage: holds one bundle and hands out its tokens, one beat
// per cycle while m_ready is high, on the result channel. Depends on slt_pkg.
module slt_back
    import slt_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    q_empty,
    input  bundle_t q_head,
    output logic    pop,
    output logic    m_valid,
    input  logic    m_ready,
    output logic [5:0]          m_token_type,
    output logic [POS_BITS-1:0] m_start_pos,
    output logic [POS_BITS-1:0] m_length,
    output logic [POS_BITS-1:0] m_line_no,
    output logic    m_is_last
);

    bundle_t    cur_reg;
    logic [1:0] idx_reg;
    logic       have_reg;
    logic       take;
    logic       last_in;
    tok_t       cur_tok;

    assign m_valid = have_reg;
    assign take    = have_reg && m_ready;
    assign last_in = (idx_reg == cur_reg.cnt - 2'd1);
    // Refill when empty or when the last token of the bundle leaves
    assign pop     = !q_empty && (!have_reg || (take && last_in));

    // Token select
    always_comb begin
        case (idx_reg)
            2'd0:    cur_tok = cur_reg.tok[0];
            2'd1:    cur_tok = cur_reg.tok[1];
            default: cur_tok = cur_reg.tok[2];
        endcase
    end

    assign m_token_type = cur_tok.ttype;
    assign m_start_pos  = cur_tok.start;
    assign m_length     = cur_tok.len;
    assign m_line_no    = cur_tok.line;
    assign m_is_last    = cur_reg.last && last_in;

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (pop) begin
            have_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (take) begin
            if (last_in) begin
                have_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Bundle payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= q_head;
        end
    end

    // Checks
    a_idx_in_bundle: assert property (@(posedge aclk) disable iff (!aresetn)
        have_reg |-> cur_reg.cnt != 2'd0 && idx_reg < cur_reg.cnt)
        else $error("token index outside held bundle");

endmodule
